// ===== rtl/quoted_string_unescape_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quoted string unescape block
// Shared concurrent assertion forms, clocked and gated by the synchronous reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_STRING_UNESCAPE_ASSERT_SVH
`define QUOTED_STRING_UNESCAPE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define QSU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define QSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qsu_pkg.sv =====
// ----------------------------------------------------------------------------
// qsu_pkg
// Types, character codes and helpers shared by the quoted string unescape block.
// ----------------------------------------------------------------------------
package qsu_pkg;

  // Character codes that steer the decoder.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_X      = 8'h78;

  // Decoder phase.
  typedef enum logic [2:0] {
    PH_SEEK = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  // Line outcome reported on a result beat.
  typedef enum logic [1:0] {
    OUT_NONE = 2'd0,
    OUT_OK   = 2'd1,
    OUT_FAIL = 2'd2
  } outcome_t;

  // Classification of one raw byte.
  typedef struct packed {
    logic       allowed;
    logic       is_quote;
    logic       is_bslash;
    logic       is_x;
    logic       hex_ok;
    logic [3:0] hex_val;
  } class_t;

  // One result beat.
  typedef struct packed {
    outcome_t   outcome;
    logic       byte_valid;
    logic [7:0] byte_out;
  } result_t;

endpackage

// ===== rtl/qsu_class.sv =====
// ----------------------------------------------------------------------------
// qsu_class
// Byte classifier: printable or whitespace range, special characters, hex digit.
// ----------------------------------------------------------------------------
module qsu_class (
  input  logic [7:0]      char_in,
  output qsu_pkg::class_t cls
);

  logic       is_dec;
  logic       is_lower;
  logic       is_upper;
  logic [7:0] hex_full;

  // Range checks for the digit classes.
  assign is_dec   = (char_in >= 8'h30) && (char_in <= 8'h39);
  assign is_lower = (char_in >= 8'h61) && (char_in <= 8'h66);
  assign is_upper = (char_in >= 8'h41) && (char_in <= 8'h46);

  // Digit value; the letter cases add ten after removing their base.
  always_comb begin
    if (is_dec) begin
      hex_full = char_in - 8'h30;
    end else if (is_lower) begin
      hex_full = char_in - 8'h57;
    end else if (is_upper) begin
      hex_full = char_in - 8'h37;
    end else begin
      hex_full = 8'h00;
    end
  end

  // Assemble the classification.
  always_comb begin
    cls.allowed   = ((char_in >= 8'h20) && (char_in <= 8'h7E)) ||
                    ((char_in >= 8'h09) && (char_in <= 8'h0D));
    cls.is_quote  = (char_in == qsu_pkg::CH_QUOTE);
    cls.is_bslash = (char_in == qsu_pkg::CH_BSLASH);
    cls.is_x      = (char_in == qsu_pkg::CH_X);
    cls.hex_ok    = is_dec || is_lower || is_upper;
    cls.hex_val   = hex_full[3:0];
  end

endmodule

// ===== rtl/qsu_fsm.sv =====
// ----------------------------------------------------------------------------
// qsu_fsm
// Decoder state machine: phase and pending hex digit, result of one byte.
// ----------------------------------------------------------------------------
`include "quoted_string_unescape_assert.svh"

module qsu_fsm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [7:0]       char_in,
  input  logic             line_end,
  input  qsu_pkg::class_t  cls,
  output qsu_pkg::result_t res
);

  qsu_pkg::phase_t phase_r;
  qsu_pkg::phase_t phase_nxt;
  logic [3:0]      high_nibble_r;
  logic [3:0]      high_nibble_nxt;

  // Result of the current byte in the current phase.
  always_comb begin
    res.byte_out   = 8'h00;
    res.byte_valid = 1'b0;
    res.outcome    = qsu_pkg::OUT_NONE;
    unique case (phase_r)
      qsu_pkg::PH_SEEK: begin
        if (line_end) begin
          res.outcome = qsu_pkg::OUT_FAIL;
        end
      end
      qsu_pkg::PH_STR: begin
        if (!cls.allowed) begin
          res.outcome = qsu_pkg::OUT_FAIL;
        end else if (cls.is_quote) begin
          res.outcome = qsu_pkg::OUT_OK;
        end else if (cls.is_bslash) begin
          if (line_end) begin
            res.outcome = qsu_pkg::OUT_FAIL;
          end
        end else begin
          res.byte_out   = char_in;
          res.byte_valid = 1'b1;
          if (line_end) begin
            res.outcome = qsu_pkg::OUT_OK;
          end
        end
      end
      qsu_pkg::PH_ESC: begin
        if (cls.is_bslash || cls.is_quote) begin
          res.byte_out   = char_in;
          res.byte_valid = 1'b1;
          if (line_end) begin
            res.outcome = qsu_pkg::OUT_OK;
          end
        end else if (!cls.is_x || line_end) begin
          res.outcome = qsu_pkg::OUT_FAIL;
        end
      end
      qsu_pkg::PH_HEX1: begin
        if (!cls.hex_ok || line_end) begin
          res.outcome = qsu_pkg::OUT_FAIL;
        end
      end
      qsu_pkg::PH_HEX2: begin
        if (!cls.hex_ok) begin
          res.outcome = qsu_pkg::OUT_FAIL;
        end else begin
          res.byte_out   = {high_nibble_r, cls.hex_val};
          res.byte_valid = 1'b1;
          if (line_end) begin
            res.outcome = qsu_pkg::OUT_OK;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Next phase; any outcome parks the line, and a line end always rearms.
  always_comb begin
    phase_nxt       = phase_r;
    high_nibble_nxt = high_nibble_r;
    unique case (phase_r)
      qsu_pkg::PH_SEEK: begin
        if (cls.is_quote) begin
          phase_nxt = qsu_pkg::PH_STR;
        end
      end
      qsu_pkg::PH_STR: begin
        if (cls.is_bslash) begin
          phase_nxt = qsu_pkg::PH_ESC;
        end
      end
      qsu_pkg::PH_ESC: begin
        if (cls.is_x) begin
          phase_nxt = qsu_pkg::PH_HEX1;
        end else begin
          phase_nxt = qsu_pkg::PH_STR;
        end
      end
      qsu_pkg::PH_HEX1: begin
        high_nibble_nxt = cls.hex_ok ? cls.hex_val : high_nibble_r;
        phase_nxt       = qsu_pkg::PH_HEX2;
      end
      qsu_pkg::PH_HEX2: begin
        phase_nxt = qsu_pkg::PH_STR;
      end
      default: begin
        phase_nxt = qsu_pkg::PH_DONE;
      end
    endcase
    if (res.outcome != qsu_pkg::OUT_NONE) begin
      phase_nxt = qsu_pkg::PH_DONE;
    end
    if (line_end) begin
      phase_nxt = qsu_pkg::PH_SEEK;
    end
  end

  // State registers, updated when a byte moves on to the result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= qsu_pkg::PH_SEEK;
      high_nibble_r <= 4'h0;
    end else if (adv) begin
      phase_r       <= phase_nxt;
      high_nibble_r <= high_nibble_nxt;
    end
  end

  // A decoded byte never comes with a failure.
  `QSU_ASSERT_SAME(a_valid_not_fail, clk, rst_n, res.byte_valid,
    res.outcome != qsu_pkg::OUT_FAIL, "decoded byte on a failing beat")

  // A line end always rearms the search for the opening quote.
  `QSU_ASSERT_NEXT(a_end_rearms, clk, rst_n, adv && line_end,
    phase_r == qsu_pkg::PH_SEEK, "line end did not return to seek")

  // An outcome in mid-line parks the decoder until the line end.
  `QSU_ASSERT_NEXT(a_outcome_parks, clk, rst_n,
    adv && !line_end && (res.outcome != qsu_pkg::OUT_NONE),
    phase_r == qsu_pkg::PH_DONE, "outcome did not park the line")

  // Once decided, bytes give empty results.
  `QSU_ASSERT_SAME(a_done_silent, clk, rst_n, phase_r == qsu_pkg::PH_DONE,
    !res.byte_valid && (res.outcome == qsu_pkg::OUT_NONE),
    "result produced after the line was decided")

endmodule

// ===== rtl/quoted_string_unescape.sv =====
// ----------------------------------------------------------------------------
// quoted_string_unescape
// Decodes the quoted string of a text line, one byte per beat, with escapes.
// ----------------------------------------------------------------------------
//  Channel  Ports        Payload
//  input    in_t*        tdata[7:0] raw byte, tlast marks the line's last byte
//  result   out_t*       tdata[7:0] decoded byte, tuser byte valid and outcome
//
//  One beat is taken every cycle while the result side does not stall; a result
//  passes through the input register and then the result register.
//  Reset is synchronous and active low; it clears both stage valids and
//  returns the decoder to the search for an opening quote.
//  A stalled result holds its register, and input keeps flowing until the
//  input register is also full.
// ----------------------------------------------------------------------------
module quoted_string_unescape (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic       in_tlast,   // line_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] byte_out
  output logic [7:0] out_tuser   // [0] byte_valid, [2:1] outcome, [7:3] zero
);

  logic             in_valid_r;
  logic [7:0]       in_char_r;
  logic             in_last_r;
  logic             out_valid_r;
  qsu_pkg::result_t out_res_r;
  logic             adv;
  qsu_pkg::class_t  cls;
  qsu_pkg::result_t res;

  // Handshake: the input stage moves on when the result register is free.
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Byte classification and decoder state machine.
  qsu_class u_class (
    .char_in (in_char_r),
    .cls     (cls)
  );

  qsu_fsm u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .char_in  (in_char_r),
    .line_end (in_last_r),
    .cls      (cls),
    .res      (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.byte_out;
  assign out_tuser  = {5'b00000, out_res_r.outcome, out_res_r.byte_valid};

endmodule
